/* design/ptw_pkg.sv */
// Shared types and constants for the four-level page table walker.
package ptw_pkg;

  // Command codes.
  localparam logic [2:0] CMD_LOOKUP   = 3'd0;
  localparam logic [2:0] CMD_MAP      = 3'd1;
  localparam logic [2:0] CMD_CLEAR    = 3'd2;
  localparam logic [2:0] CMD_DIRTY    = 3'd3;
  localparam logic [2:0] CMD_ACCESSED = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_TABLE = 2'd1;
  localparam logic [1:0] STAT_NO_FRAME = 2'd2;

  // Entry flag bit positions.
  localparam int F_P = 0;
  localparam int F_W = 1;
  localparam int F_U = 2;
  localparam int F_A = 5;
  localparam int F_D = 6;

  localparam int PAGE_SHIFT = 12;
  localparam int IDX_BITS   = 9;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_CHECK,
    ST_ZERO,
    ST_LINK,
    ST_ROLL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] virt_addr;
    logic [51:0] frame_addr;
    logic        writable;
    logic        flag_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        present;
    logic [51:0] phys_addr;
    logic        dirty;
    logic        accessed;
    logic        tlb_invalidate;
  } resp_t;

endpackage

/* design/ptw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/four_level_page_table_walker_unit.sv */
// Top level of the four-level page table walker: sequencer, table store and frame pool map.
// Each level is read (ST_READ) and then decoded (ST_CHECK); when the walk ends the result
// is posted from ST_DONE, and a new request is taken only back in ST_IDLE, once the output
// is free. A map that creates a level scans the pool for a free frame, then zeroes and links
// it; running out of frames rolls back each level created by that map.
// Reset is synchronous; after it a clearing pass over all POOL_FRAMES * 512 table entries
// runs before the first request is taken, while configuration writes are accepted throughout.
module four_level_page_table_walker_unit #(
  parameter int POOL_FRAMES    = 64,
  parameter int PHYS_ADDR_BITS = 52
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ptw_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ptw_pkg::resp_t out_data,
  input  logic           cfg_en,
  input  logic           cfg_data
);

  localparam int FW = $clog2(POOL_FRAMES);
  localparam int AW = FW + ptw_pkg::IDX_BITS;
  localparam logic [63:0] AMASK = ((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'hFFF;
  localparam logic [FW-1:0] LAST_FRAME = FW'(POOL_FRAMES - 1);
  localparam logic [FW-1:0] ONE_FRAME  = FW'(1);
  localparam logic [ptw_pkg::IDX_BITS-1:0] LAST_IDX = '1;
  localparam logic [ptw_pkg::IDX_BITS-1:0] ONE_IDX  = ptw_pkg::IDX_BITS'(1);

  ptw_pkg::state_t state, state_next;
  ptw_pkg::req_t   req;
  ptw_pkg::resp_t  res;
  logic            root_active;
  logic [1:0]      level;
  logic [FW-1:0]   frame;
  logic [FW-1:0]   cnt_frame;
  logic [ptw_pkg::IDX_BITS-1:0] cnt_idx;
  logic [FW-1:0]   nf;
  logic [1:0]      made_cnt;
  logic [1:0]      roll_cnt;
  logic [AW-1:0]   made_entry [3];
  logic [FW-1:0]   made_frame [3];

  // Memory ports.
  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [63:0]   tbl_wdata;
  logic [AW-1:0] tbl_raddr;
  logic [63:0]   tbl_rdata;
  logic          use_we;
  logic [FW-1:0] use_waddr;
  logic          use_wdata;
  logic          use_rdata;

  ptw_ram #(.WIDTH(64), .DEPTH(POOL_FRAMES * 512)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  ptw_ram #(.WIDTH(1), .DEPTH(POOL_FRAMES)) u_in_use (
    .clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
    .raddr(cnt_frame), .rdata(use_rdata)
  );

  // Index of the current level taken from the virtual address.
  logic [ptw_pkg::IDX_BITS-1:0] idx;
  logic [AW-1:0] cur_addr;
  always_comb begin
    case (level)
      2'd0:    idx = req.virt_addr[47:39];
      2'd1:    idx = req.virt_addr[38:30];
      2'd2:    idx = req.virt_addr[29:21];
      default: idx = req.virt_addr[20:12];
    endcase
  end
  assign cur_addr  = {frame, idx};
  assign tbl_raddr = cur_addr;

  // Decode of the entry just read.
  logic [63:0] child_full;
  logic        child_ok;
  logic        e_present;
  logic        create;
  assign child_full = (tbl_rdata & AMASK) >> ptw_pkg::PAGE_SHIFT;
  assign child_ok   = child_full < 64'(POOL_FRAMES);
  assign e_present  = tbl_rdata[ptw_pkg::F_P];
  assign create     = req.command == ptw_pkg::CMD_MAP;

  // Leaf action for each command.
  logic [63:0] leaf_new;
  logic        leaf_wr;
  logic        leaf_tlb;
  logic [51:0] leaf_phys;
  always_comb begin
    leaf_new  = tbl_rdata;
    leaf_wr   = 1'b0;
    leaf_tlb  = 1'b0;
    leaf_phys = '0;
    case (req.command)
      ptw_pkg::CMD_LOOKUP: begin
        if (e_present) begin
          leaf_phys = 52'((tbl_rdata & AMASK) | {52'd0, req.virt_addr[11:0]});
        end
      end
      ptw_pkg::CMD_MAP: begin
        leaf_new = ({12'd0, req.frame_addr} & AMASK) | 64'h5
                   | {62'd0, req.writable, 1'b0};
        leaf_wr  = 1'b1;
      end
      ptw_pkg::CMD_CLEAR: begin
        if (e_present) begin
          leaf_new[ptw_pkg::F_P] = 1'b0;
          leaf_wr  = 1'b1;
          leaf_tlb = root_active;
        end
      end
      ptw_pkg::CMD_DIRTY: begin
        leaf_new[ptw_pkg::F_D] = req.flag_value;
        leaf_wr  = 1'b1;
        leaf_tlb = root_active;
      end
      default: begin
        leaf_new[ptw_pkg::F_A] = req.flag_value;
        leaf_wr  = 1'b1;
        leaf_tlb = root_active;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ptw_pkg::ST_CLEAR: begin
        if (cnt_frame == LAST_FRAME && cnt_idx == LAST_IDX) state_next = ptw_pkg::ST_IDLE;
      end
      ptw_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.command > ptw_pkg::CMD_ACCESSED) ?
                       ptw_pkg::ST_DONE : ptw_pkg::ST_READ;
        end
      end
      ptw_pkg::ST_READ: state_next = ptw_pkg::ST_CHECK;
      ptw_pkg::ST_CHECK: begin
        if (level == 2'd3) begin
          state_next = ptw_pkg::ST_DONE;
        end else if (!e_present) begin
          state_next = create ? ptw_pkg::ST_SCAN : ptw_pkg::ST_DONE;
        end else if (!child_ok) begin
          state_next = (made_cnt != 2'd0) ? ptw_pkg::ST_ROLL : ptw_pkg::ST_DONE;
        end else begin
          state_next = ptw_pkg::ST_READ;
        end
      end
      ptw_pkg::ST_SCAN: state_next = ptw_pkg::ST_SCAN_CHECK;
      ptw_pkg::ST_SCAN_CHECK: begin
        if (!use_rdata) begin
          state_next = ptw_pkg::ST_ZERO;
        end else if (cnt_frame == LAST_FRAME) begin
          state_next = (made_cnt != 2'd0) ? ptw_pkg::ST_ROLL : ptw_pkg::ST_DONE;
        end else begin
          state_next = ptw_pkg::ST_SCAN;
        end
      end
      ptw_pkg::ST_ZERO: begin
        if (cnt_idx == LAST_IDX) state_next = ptw_pkg::ST_LINK;
      end
      ptw_pkg::ST_LINK: state_next = ptw_pkg::ST_READ;
      ptw_pkg::ST_ROLL: begin
        if (roll_cnt == made_cnt - 2'd1) state_next = ptw_pkg::ST_DONE;
      end
      ptw_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ptw_pkg::ST_IDLE;
      end
      default: state_next = ptw_pkg::ST_CLEAR;
    endcase
  end

  // Memory write controls.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = cur_addr;
    tbl_wdata = '0;
    use_we    = 1'b0;
    use_waddr = cnt_frame;
    use_wdata = 1'b0;
    case (state)
      ptw_pkg::ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {cnt_frame, cnt_idx};
        use_we    = cnt_idx == '0;
        use_wdata = cnt_frame == '0;
      end
      ptw_pkg::ST_CHECK: begin
        if (level == 2'd3) begin
          tbl_we    = leaf_wr;
          tbl_wdata = leaf_new;
        end
      end
      ptw_pkg::ST_SCAN_CHECK: begin
        use_we    = !use_rdata;
        use_wdata = 1'b1;
      end
      ptw_pkg::ST_ZERO: begin
        tbl_we    = 1'b1;
        tbl_waddr = {nf, cnt_idx};
      end
      ptw_pkg::ST_LINK: begin
        tbl_we    = 1'b1;
        tbl_wdata = (64'(nf) << ptw_pkg::PAGE_SHIFT) | 64'h7;
      end
      ptw_pkg::ST_ROLL: begin
        tbl_we    = 1'b1;
        tbl_waddr = made_entry[roll_cnt];
        use_we    = 1'b1;
        use_waddr = made_frame[roll_cnt];
      end
      default: begin
      end
    endcase
  end

  assign in_stall = state != ptw_pkg::ST_IDLE;

  // Sequencer registers and walk datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ptw_pkg::ST_CLEAR;
      cnt_frame   <= '0;
      cnt_idx     <= '0;
      made_cnt    <= '0;
      roll_cnt    <= '0;
      out_valid   <= 1'b0;
      root_active <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_en) root_active <= cfg_data;
      if (state == ptw_pkg::ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ptw_pkg::ST_CLEAR: begin
          cnt_idx <= cnt_idx + ONE_IDX;
          if (cnt_idx == LAST_IDX) cnt_frame <= cnt_frame + ONE_FRAME;
        end
        ptw_pkg::ST_IDLE: begin
          if (in_valid) begin
            req      <= in_data;
            level    <= 2'd0;
            frame    <= '0;
            made_cnt <= '0;
            roll_cnt <= '0;
            res      <= '0;
          end
        end
        ptw_pkg::ST_CHECK: begin
          if (level == 2'd3) begin
            res.status         <= ptw_pkg::STAT_OK;
            res.present        <= leaf_new[ptw_pkg::F_P];
            res.dirty          <= leaf_new[ptw_pkg::F_D];
            res.accessed       <= leaf_new[ptw_pkg::F_A];
            res.phys_addr      <= leaf_phys;
            res.tlb_invalidate <= leaf_tlb;
          end else if (!e_present) begin
            if (create) cnt_frame <= '0;
            else res.status <= ptw_pkg::STAT_NO_TABLE;
          end else if (!child_ok) begin
            res.status <= create ? ptw_pkg::STAT_NO_FRAME : ptw_pkg::STAT_NO_TABLE;
          end else begin
            frame <= child_full[FW-1:0];
            level <= level + 2'd1;
          end
        end
        ptw_pkg::ST_SCAN_CHECK: begin
          if (!use_rdata) begin
            nf      <= cnt_frame;
            cnt_idx <= '0;
          end else if (cnt_frame == LAST_FRAME) begin
            res.status <= ptw_pkg::STAT_NO_FRAME;
          end else begin
            cnt_frame <= cnt_frame + ONE_FRAME;
          end
        end
        ptw_pkg::ST_ZERO: cnt_idx <= cnt_idx + ONE_IDX;
        ptw_pkg::ST_LINK: begin
          made_entry[made_cnt] <= cur_addr;
          made_frame[made_cnt] <= nf;
          made_cnt <= made_cnt + 2'd1;
          frame    <= nf;
          level    <= level + 2'd1;
        end
        ptw_pkg::ST_ROLL: roll_cnt <= roll_cnt + 2'd1;
        ptw_pkg::ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data <= res;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
